### rtl/core/fgcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgcs_pkg
// Shared types and constants of the font glyph column streamer.
// ----------------------------------------------------------------------------
package fgcs_pkg;

    // defaults for the top-level parameters
    localparam int DEF_FONT_BYTES = 4096;
    localparam int DEF_MAX_WIDTH  = 31;

    // field widths
    localparam int ADDR_IN_W = 12;
    localparam int BYTE_W    = 8;
    localparam int CODE_W    = 8;
    localparam int GW_W      = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 5;
    localparam int S_DATA_W  = 32;   // 28 bits of fields, padded to bytes
    localparam int M_DATA_W  = 8;
    localparam int COL_W     = 6;    // column counter, holds up to 32

    // request kinds
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_RENDER = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARSE_MODE = 1'b1;

    // font layout constants
    localparam logic [CODE_W-1:0] GLYPH_BASE   = 8'h20;
    localparam int                HEADER_LEN   = 3;
    localparam logic [BYTE_W-1:0] SPACER       = 8'h00;
    localparam logic [GW_W-1:0]   GW_RESET     = 5'd5;
    localparam logic [COL_W-1:0]  SPARSE_COLS  = 6'd8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_RED_LOAD,
        S_RED_RENDER,
        S_MASK_RD,
        S_MASK_WAIT,
        S_COLS,
        S_SPACER
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic capture;    // latch accepted item
        logic mul;        // form unreduced start address
        logic red;        // one reduction step
        logic wr;         // write font byte (last reduction step of a load)
        logic mask_rd;    // read mask byte, advance address
        logic mask_ld;    // capture mask byte
        logic col_step;   // advance column and address
        logic col_rd;     // issue column read
        logic spc;        // issue spacer column
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic red_last;
        logic sparse;
        logic col_end;
        logic col_en;
        logic space;
    } t_dp_sts;

endpackage

### rtl/core/fgcs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgcs_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fgcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/fgcs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgcs_ctrl
// Sequencer: load and render flows, column issue pacing.
// ----------------------------------------------------------------------------
module fgcs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_render,
    output logic              o_in_ready,
    input  fgcs_pkg::t_dp_sts i_sts,
    output fgcs_pkg::t_dp_cmd o_cmd
);

    fgcs_pkg::t_state r_state;
    fgcs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fgcs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            fgcs_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = i_in_render ? fgcs_pkg::S_MUL : fgcs_pkg::S_RED_LOAD;
                end
            end
            fgcs_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = fgcs_pkg::S_RED_RENDER;
            end
            fgcs_pkg::S_RED_LOAD: begin
                o_cmd.red = 1'b1;
                if (i_sts.red_last) begin
                    o_cmd.wr = 1'b1;
                    n_state  = fgcs_pkg::S_IDLE;
                end
            end
            fgcs_pkg::S_RED_RENDER: begin
                o_cmd.red = 1'b1;
                if (i_sts.red_last) begin
                    n_state = i_sts.sparse ? fgcs_pkg::S_MASK_RD : fgcs_pkg::S_COLS;
                end
            end
            fgcs_pkg::S_MASK_RD: begin
                o_cmd.mask_rd = 1'b1;
                n_state       = fgcs_pkg::S_MASK_WAIT;
            end
            fgcs_pkg::S_MASK_WAIT: begin
                o_cmd.mask_ld = 1'b1;
                n_state       = fgcs_pkg::S_COLS;
            end
            fgcs_pkg::S_COLS: begin
                if (i_sts.col_end) begin
                    n_state = fgcs_pkg::S_SPACER;
                end else if (!i_sts.col_en) begin
                    o_cmd.col_step = 1'b1;   // masked column, no read
                end else if (i_sts.space) begin
                    o_cmd.col_step = 1'b1;
                    o_cmd.col_rd   = 1'b1;
                end
            end
            fgcs_pkg::S_SPACER: begin
                if (i_sts.space) begin
                    o_cmd.spc = 1'b1;
                    n_state   = fgcs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fgcs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/fgcs_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgcs_dpath
// Config registers, address arithmetic, font RAM and two-entry output queue.
// ----------------------------------------------------------------------------
module fgcs_dpath #(
    parameter int FONT_BYTES = fgcs_pkg::DEF_FONT_BYTES,
    parameter int MAX_WIDTH  = fgcs_pkg::DEF_MAX_WIDTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [fgcs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [fgcs_pkg::CFG_DAT_W-1:0]     i_cfg_wdata,
    input  logic [fgcs_pkg::ADDR_IN_W-1:0]     i_font_addr,
    input  logic [fgcs_pkg::BYTE_W-1:0]        i_font_byte,
    input  logic [fgcs_pkg::CODE_W-1:0]        i_glyph_code,
    input  fgcs_pkg::t_dp_cmd                  i_cmd,
    output fgcs_pkg::t_dp_sts                  o_sts,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [fgcs_pkg::BYTE_W-1:0]        o_column_bits,
    output logic                               o_last_column
);

    localparam int ADDR_W  = $clog2(FONT_BYTES);
    localparam int EFF_MAX = (MAX_WIDTH < 31) ? MAX_WIDTH : 31;
    localparam int RND_MAX = 255 * (EFF_MAX + 1) + fgcs_pkg::HEADER_LEN;
    localparam int MAX_VAL = (RND_MAX > 4095) ? RND_MAX : 4095;
    localparam int K_RAW   = $clog2(MAX_VAL / FONT_BYTES + 1);
    localparam int K_STEPS = (K_RAW > 0) ? K_RAW : 1;
    localparam int STEP_W  = (K_STEPS > 1) ? $clog2(K_STEPS) : 1;
    localparam int RED_W   = $clog2(FONT_BYTES) + K_STEPS + 1;
    localparam logic [fgcs_pkg::GW_W-1:0] WLIM = fgcs_pkg::GW_W'(EFF_MAX);

    // configuration
    logic [fgcs_pkg::GW_W-1:0] r_glyph_width;
    logic                      r_sparse;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glyph_width <= fgcs_pkg::GW_RESET;
            r_sparse      <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fgcs_pkg::CFG_GLYPH_WIDTH: r_glyph_width <= i_cfg_wdata;
                fgcs_pkg::CFG_SPARSE_MODE: r_sparse      <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    localparam int COL_W_LP = fgcs_pkg::COL_W;
    logic [fgcs_pkg::GW_W-1:0] w;
    logic [COL_W_LP-1:0]       stride;
    logic [COL_W_LP-1:0]       mult;
    logic [13:0]               prod;

    assign w      = (r_glyph_width > WLIM) ? WLIM : r_glyph_width;
    assign stride = {1'b0, w} + 1'b1;
    assign mult   = r_sparse ? stride : {1'b0, w};

    // item registers
    logic [fgcs_pkg::CODE_W-1:0] r_idx;
    logic [fgcs_pkg::BYTE_W-1:0] r_byte;
    logic [RED_W-1:0]            r_val;
    logic [STEP_W-1:0]           r_step;
    logic [ADDR_W-1:0]           r_addr;
    logic [fgcs_pkg::BYTE_W-1:0] r_mask;
    logic [COL_W_LP-1:0]         r_col;

    assign prod = r_idx * mult;

    // restoring remainder, one quotient bit per step
    logic [RED_W-1:0]  red_sub;
    logic [RED_W-1:0]  n_red;
    logic [ADDR_W-1:0] red_addr;
    logic [ADDR_W-1:0] addr_inc;
    logic [fgcs_pkg::BYTE_W-1:0] ram_rdata;

    assign red_sub  = RED_W'(FONT_BYTES) << r_step;
    assign n_red    = (r_val >= red_sub) ? (r_val - red_sub) : r_val;
    assign red_addr = n_red[ADDR_W-1:0];
    assign addr_inc = (r_addr == ADDR_W'(FONT_BYTES - 1)) ? '0 : (r_addr + 1'b1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_idx  <= i_glyph_code - fgcs_pkg::GLYPH_BASE;
            r_byte <= i_font_byte;
            r_val  <= RED_W'(i_font_addr);
            r_step <= STEP_W'(K_STEPS - 1);
        end
        if (i_cmd.mul) begin
            r_val <= RED_W'(prod) + RED_W'(fgcs_pkg::HEADER_LEN);
            r_col <= '0;
        end
        if (i_cmd.red) begin
            r_val  <= n_red;
            r_step <= r_step - 1'b1;
            if (o_sts.red_last) begin
                r_addr <= red_addr;
            end
        end
        if (i_cmd.mask_rd || i_cmd.col_step) begin
            r_addr <= addr_inc;
        end
        if (i_cmd.col_step) begin
            r_col <= r_col + 1'b1;
        end
        if (i_cmd.mask_ld) begin
            r_mask <= ram_rdata;
        end
    end

    fgcs_ram #(
        .WIDTH (fgcs_pkg::BYTE_W),
        .DEPTH (FONT_BYTES)
    ) u_font_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr),
        .i_waddr (red_addr),
        .i_wdata (r_byte),
        .i_re    (i_cmd.mask_rd | i_cmd.col_rd),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    // read or spacer in flight, lands in the queue next cycle
    logic r_pend;
    logic r_pend_spc;

    // two-entry output queue, entry 0 is the head
    logic [1:0]                  r_cnt;
    logic [fgcs_pkg::BYTE_W-1:0] r_q_bits [2];
    logic                        r_q_last [2];
    logic                        pop;
    logic [1:0]                  q_wi;

    assign pop  = (r_cnt != 2'd0) && i_out_ready;
    assign q_wi = r_cnt - {1'b0, pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_pend <= i_cmd.col_rd | i_cmd.spc;
            r_cnt  <= r_cnt + {1'b0, r_pend} - {1'b0, pop};
        end
    end

    // head takes the landing column when it is the free slot, else shifts
    always_ff @(posedge i_clk) begin
        r_pend_spc <= i_cmd.spc;
        if (r_pend && (q_wi[0] == 1'b0)) begin
            r_q_bits[0] <= r_pend_spc ? fgcs_pkg::SPACER : ram_rdata;
            r_q_last[0] <= r_pend_spc;
        end else if (pop) begin
            r_q_bits[0] <= r_q_bits[1];
            r_q_last[0] <= r_q_last[1];
        end
        if (r_pend && (q_wi[0] == 1'b1)) begin
            r_q_bits[1] <= r_pend_spc ? fgcs_pkg::SPACER : ram_rdata;
            r_q_last[1] <= r_pend_spc;
        end
    end

    assign o_out_valid   = (r_cnt != 2'd0);
    assign o_column_bits = r_q_bits[0];
    assign o_last_column = r_q_last[0];

    // status
    assign o_sts.red_last = (r_step == '0);
    assign o_sts.sparse   = r_sparse;
    assign o_sts.col_end  = r_sparse ? ((r_col == stride) || (r_col == fgcs_pkg::SPARSE_COLS))
                                     : (r_col == {1'b0, w});
    assign o_sts.col_en   = !r_sparse || r_mask[r_col[2:0]];
    assign o_sts.space    = ({1'b0, r_cnt} + {2'b00, r_pend}) < (3'd2 + {2'b00, pop});

endmodule

### rtl/core/font_glyph_column_streamer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// font_glyph_column_streamer_top
// Character generator: loads a font image byte by byte and streams the
// vertical pixel column bytes of a glyph, ending with a zero spacer column.
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake              | payload
//  ----------+-----+------------------------+-------------------------------
//  s_axis    | in  | tvalid / tready        | tuser: req_type
//            |     |                        | tdata: font_addr, font_byte,
//            |     |                        |        glyph_code
//  m_axis    | out | tvalid / tready        | tdata: column_bits
//            |     |                        | tlast: last_column
//  cfg       | in  | we (no wait)           | idx, wdata
//
//  Flow: a load reduces its address in K remainder steps and writes the
//  byte; a render reduces its start address, reads the mask byte in sparse
//  mode and issues columns, then the spacer. K is the number of remainder
//  steps of the address reduction unit (1 for a 4096-byte font). Columns
//  issue at one per cycle from the RAM read port while the queue has room.
//  Reset: synchronous, active low; width resets to 5, dense mode. The font
//  RAM is not cleared and holds garbage until written.
//  Stalls: a two-entry output queue takes columns while the output is
//  stalled; column reads pause only when the queue would overflow. A new
//  item is accepted once a load has written or a render issued its spacer.
//
module font_glyph_column_streamer_top #(
    parameter int FONT_BYTES = fgcs_pkg::DEF_FONT_BYTES,
    parameter int MAX_WIDTH  = fgcs_pkg::DEF_MAX_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input items
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [11:0] font_addr, [19:12] font_byte, [27:20] glyph_code, [31:28] zero
    input  logic [fgcs_pkg::S_DATA_W-1:0]       i_s_axis_tdata,
    // [0] req_type
    input  logic                                i_s_axis_tuser,
    // result items
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [7:0] column_bits
    output logic [fgcs_pkg::M_DATA_W-1:0]       o_m_axis_tdata,
    output logic                                o_m_axis_tlast,
    // configuration writes
    input  logic                                i_cfg_we,
    input  logic [fgcs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [fgcs_pkg::CFG_DAT_W-1:0]      i_cfg_wdata
);

    fgcs_pkg::t_dp_cmd cmd;
    fgcs_pkg::t_dp_sts sts;

    // unpack input fields
    logic [fgcs_pkg::ADDR_IN_W-1:0] font_addr;
    logic [fgcs_pkg::BYTE_W-1:0]    font_byte;
    logic [fgcs_pkg::CODE_W-1:0]    glyph_code;

    assign font_addr  = i_s_axis_tdata[11:0];
    assign font_byte  = i_s_axis_tdata[19:12];
    assign glyph_code = i_s_axis_tdata[27:20];

    fgcs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_render (i_s_axis_tuser == fgcs_pkg::REQ_RENDER),
        .o_in_ready  (o_s_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    fgcs_dpath #(
        .FONT_BYTES (FONT_BYTES),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_font_addr   (font_addr),
        .i_font_byte   (font_byte),
        .i_glyph_code  (glyph_code),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_valid   (o_m_axis_tvalid),
        .i_out_ready   (i_m_axis_tready),
        .o_column_bits (o_m_axis_tdata),
        .o_last_column (o_m_axis_tlast)
    );

endmodule

### tb/sv/font_glyph_column_streamer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// font_glyph_column_streamer_top_tb
// Loads the font bytes that each rendered glyph needs, then renders characters
// under several width / layout settings. A scoreboard class mirrors the font
// RAM and the two registers, predicts every column byte of each rendered
// glyph, and checks the streamed columns in order. The sender works in
// bursts and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module font_glyph_column_streamer_top_tb;

    localparam int FONT_SIZE       = fgcs_pkg::DEF_FONT_BYTES;
    localparam int SPARSE_DATA_OFS = fgcs_pkg::HEADER_LEN + 1;  // first column after the mask
    localparam int SETTLE_CYCLES   = 16;              // covers a load still in flight
    localparam int RANDOM_ITEMS    = 16;              // per setting
    localparam int NUM_SETTINGS    = 6;               // after the reset setting
    localparam int PAD_W           = fgcs_pkg::S_DATA_W - fgcs_pkg::CODE_W
                                     - fgcs_pkg::BYTE_W - fgcs_pkg::ADDR_IN_W;
    localparam int CFG_PAD_W       = fgcs_pkg::CFG_DAT_W - 1;
    localparam int MAX_REPORTS     = 40;
    localparam int NEAR_ADDR_MAX   = 63;              // covers glyph 0 at every width
    // glyph index 255
    localparam logic [fgcs_pkg::CODE_W-1:0] LAST_CODE = 8'h1F;
    // glyph index 132: at dense width 31 its columns cross the top address
    localparam logic [fgcs_pkg::CODE_W-1:0] WRAP_CODE = 8'hA4;

    typedef struct {
        logic [fgcs_pkg::M_DATA_W-1:0] bits;
        logic                          last;
    } t_column;

    typedef enum int {
        RX_FREE,
        RX_RANDOM,
        RX_PERIODIC
    } t_rx_mode;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the font RAM and registers, queue of columns
    // still owed by the block.
    // ------------------------------------------------------------------------
    class glyph_scoreboard;
        logic [fgcs_pkg::BYTE_W-1:0] font_mem [FONT_SIZE];
        bit                          written  [FONT_SIZE];
        logic [fgcs_pkg::GW_W-1:0]   width;
        logic                        sparse;
        t_column                     owed_cols[$];
        int                          mismatches;
        int                          loads;
        int                          renders;
        int                          columns;

        function new();
            width      = fgcs_pkg::GW_RESET;
            sparse     = 1'b0;
            mismatches = 0;
            loads      = 0;
            renders    = 0;
            columns    = 0;
        endfunction

        task report(string msg);
            if (mismatches < MAX_REPORTS)
                $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        function void set_reg(logic [fgcs_pkg::CFG_IDX_W-1:0] idx,
                              logic [fgcs_pkg::CFG_DAT_W-1:0] value);
            if (idx == fgcs_pkg::CFG_GLYPH_WIDTH)
                width = value[fgcs_pkg::GW_W-1:0];
            else
                sparse = value[0];
        endfunction

        function int pending();
            return owed_cols.size();
        endfunction

        function int eff_width();
            int w;
            w = width;
            if (w > fgcs_pkg::DEF_MAX_WIDTH)
                w = fgcs_pkg::DEF_MAX_WIDTH;
            return w;
        endfunction

        // First font address that rendering code would read before it was
        // ever loaded, or -1 when the glyph is fully loaded.
        function int missing_addr(logic [fgcs_pkg::CODE_W-1:0] code);
            logic [fgcs_pkg::CODE_W-1:0] idx;
            logic [fgcs_pkg::BYTE_W-1:0] mask;
            int                          w;
            int                          base;
            int                          a;
            idx = code - fgcs_pkg::GLYPH_BASE;
            w   = eff_width();
            if (!sparse) begin
                base = int'(idx) * w + fgcs_pkg::HEADER_LEN;
                for (int col = 0; col < w; col++) begin
                    a = (base + col) % FONT_SIZE;
                    if (!written[a])
                        return a;
                end
            end else begin
                base = int'(idx) * (w + 1);
                a    = (base + fgcs_pkg::HEADER_LEN) % FONT_SIZE;
                if (!written[a])
                    return a;
                mask = font_mem[a];
                for (int col = 0; col < w + 1 && col < int'(fgcs_pkg::SPARSE_COLS); col++) begin
                    a = (base + SPARSE_DATA_OFS + col) % FONT_SIZE;
                    if (mask[col] && !written[a])
                        return a;
                end
            end
            return -1;
        endfunction

        function void owe(logic [fgcs_pkg::M_DATA_W-1:0] bits, logic last);
            t_column c;
            c.bits = bits;
            c.last = last;
            owed_cols.push_back(c);
        endfunction

        // Called for every accepted input item.
        function void note_input(logic req, logic [fgcs_pkg::ADDR_IN_W-1:0] addr,
                                 logic [fgcs_pkg::BYTE_W-1:0] fbyte,
                                 logic [fgcs_pkg::CODE_W-1:0] code);
            logic [fgcs_pkg::CODE_W-1:0] idx;
            logic [fgcs_pkg::BYTE_W-1:0] mask;
            int                          w;
            int                          base;
            int                          stride;
            if (req == fgcs_pkg::REQ_LOAD) begin
                font_mem[addr] = fbyte;
                written[addr]  = 1'b1;
                loads++;
                return;
            end
            renders++;
            idx = code - fgcs_pkg::GLYPH_BASE;
            w   = eff_width();
            if (!sparse) begin
                base = int'(idx) * w + fgcs_pkg::HEADER_LEN;
                for (int col = 0; col < w; col++)
                    owe(font_mem[(base + col) % FONT_SIZE], 1'b0);
            end else begin
                stride = w + 1;
                base   = int'(idx) * stride;
                mask   = font_mem[(base + fgcs_pkg::HEADER_LEN) % FONT_SIZE];
                // mask has 8 bits, so columns past 7 never show up
                for (int col = 0; col < stride && col < int'(fgcs_pkg::SPARSE_COLS); col++)
                    if (mask[col])
                        owe(font_mem[(base + SPARSE_DATA_OFS + col) % FONT_SIZE], 1'b0);
            end
            owe(fgcs_pkg::SPACER, 1'b1);
        endfunction

        // Called for every accepted result item.
        task check_column(logic [fgcs_pkg::M_DATA_W-1:0] bits, logic last);
            t_column want;
            if (owed_cols.size() == 0) begin
                report($sformatf("unexpected column %02h last %0b", bits, last));
                return;
            end
            want = owed_cols.pop_front();
            columns++;
            if (bits !== want.bits)
                report($sformatf("column_bits %02h, expected %02h", bits, want.bits));
            if (last !== want.last)
                report($sformatf("last_column %0b, expected %0b", last, want.last));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs (all known from time zero)
    // ------------------------------------------------------------------------
    logic                           i_clk     = 1'b0;
    logic                           i_rst_n   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic [fgcs_pkg::S_DATA_W-1:0]  s_tdata   = '0;
    logic                           s_tuser   = 1'b0;
    logic                           m_tready  = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [fgcs_pkg::CFG_IDX_W-1:0] cfg_idx   = '0;
    logic [fgcs_pkg::CFG_DAT_W-1:0] cfg_wdata = '0;

    logic                           o_s_axis_tready;
    logic                           o_m_axis_tvalid;
    logic [fgcs_pkg::M_DATA_W-1:0]  o_m_axis_tdata;
    logic                           o_m_axis_tlast;

    glyph_scoreboard sb;

    always #5 i_clk = ~i_clk;

    font_glyph_column_streamer_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // Receiver: switches between free-running, random stalls and a fixed
    // 2-of-5 ready pattern, picking the mode at random.
    // ------------------------------------------------------------------------
    t_rx_mode rx_mode = RX_FREE;
    int       rx_left = 0;
    int       rx_tick = 0;

    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 2));
            rx_left = $urandom_range(50, 300);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            RX_FREE: begin
                m_tready <= 1'b1;
            end
            RX_RANDOM: begin
                m_tready <= ($urandom_range(0, 2) != 0);
            end
            default: begin
                m_tready <= ((rx_tick % 5) < 2);
            end
        endcase
    end

    // Result monitor: values read here are the ones from before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && m_tready)
            sb.check_column(o_m_axis_tdata, o_m_axis_tlast);
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------
    int burst_left = 0;

    // Opens a new burst when the last one is used up; a quarter of the bursts
    // follow the previous one with no gap at all.
    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    // Valid stays high after acceptance; pace() or settle() lowers it.
    task automatic send_item(input logic req, input logic [fgcs_pkg::ADDR_IN_W-1:0] addr,
                             input logic [fgcs_pkg::BYTE_W-1:0] fbyte,
                             input logic [fgcs_pkg::CODE_W-1:0] code);
        pace();
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {{PAD_W{1'b0}}, code, fbyte, addr};
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_input(req, addr, fbyte, code);
    endtask

    // Loads every byte the glyph would read that was never loaded, then
    // renders it.
    task automatic render(input logic [fgcs_pkg::CODE_W-1:0] code);
        int a;
        a = sb.missing_addr(code);
        while (a >= 0) begin
            send_item(fgcs_pkg::REQ_LOAD, fgcs_pkg::ADDR_IN_W'(a),
                      fgcs_pkg::BYTE_W'($urandom), fgcs_pkg::CODE_W'($urandom));
            a = sb.missing_addr(code);
        end
        send_item(fgcs_pkg::REQ_RENDER, fgcs_pkg::ADDR_IN_W'($urandom),
                  fgcs_pkg::BYTE_W'($urandom), code);
    endtask

    // Mostly renders; loads keep rewriting font bytes, half of them under
    // glyph 0. A random code that still needs loads falls back to a glyph
    // that is already in place.
    task automatic run_random(input int n);
        logic [fgcs_pkg::CODE_W-1:0] code;
        int                          addr;
        for (int i = 0; i < n; i++) begin
            code = fgcs_pkg::CODE_W'($urandom);
            if ($urandom_range(0, 3) == 0) begin
                addr = ($urandom_range(0, 1) == 0) ? $urandom_range(0, NEAR_ADDR_MAX)
                                                   : $urandom_range(0, FONT_SIZE - 1);
                send_item(fgcs_pkg::REQ_LOAD, fgcs_pkg::ADDR_IN_W'(addr),
                          fgcs_pkg::BYTE_W'($urandom), code);
            end else begin
                if (sb.missing_addr(code) >= 0)
                    code = ($urandom_range(0, 1) == 0) ? fgcs_pkg::GLYPH_BASE : LAST_CODE;
                render(code);
            end
        end
    endtask

    // Idle the input, wait for every owed column, then let a trailing load
    // finish inside the block.
    task automatic settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write; the extra edge keeps two writes from sharing a step.
    task automatic cfg_write(input logic [fgcs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fgcs_pkg::CFG_DAT_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, value);
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    int   set_width [NUM_SETTINGS];
    logic set_sparse[NUM_SETTINGS];

    initial begin
        sb = new();
        // dense extremes, then sparse with the mask-layout extremes, then one
        // random setting
        set_width  = '{0, 31, 7, 0, 31, 0};
        set_sparse = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
        set_width[NUM_SETTINGS-1]  = $urandom_range(0, 31);
        set_sparse[NUM_SETTINGS-1] = $urandom_range(0, 1);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset setting: 5 columns, dense. Address and byte extremes, then
        // glyph index 0, 255 and a code below the printable base.
        send_item(fgcs_pkg::REQ_LOAD, '0, '1, '0);
        send_item(fgcs_pkg::REQ_LOAD, '1, '0, '1);
        render(fgcs_pkg::GLYPH_BASE);
        render(LAST_CODE);
        render(8'h00);
        run_random(RANDOM_ITEMS);

        for (int s = 0; s < NUM_SETTINGS; s++) begin
            settle();
            cfg_write(fgcs_pkg::CFG_GLYPH_WIDTH, fgcs_pkg::CFG_DAT_W'(set_width[s]));
            // upper wdata bits are don't-care for the layout flag
            cfg_write(fgcs_pkg::CFG_SPARSE_MODE,
                      {CFG_PAD_W'($urandom_range(0, 15)), set_sparse[s]});
            if (set_sparse[s] && set_width[s] == 7) begin
                // full mask on glyph 0, empty mask on glyph 1 (stride 8)
                send_item(fgcs_pkg::REQ_LOAD, fgcs_pkg::ADDR_IN_W'(fgcs_pkg::HEADER_LEN),
                          8'hFF, '0);
                send_item(fgcs_pkg::REQ_LOAD, fgcs_pkg::ADDR_IN_W'(fgcs_pkg::HEADER_LEN + 8),
                          8'h00, '0);
                render(fgcs_pkg::GLYPH_BASE + 8'd1);
            end
            if (!set_sparse[s] && set_width[s] == 31)
                render(WRAP_CODE);
            render(fgcs_pkg::GLYPH_BASE);
            render(LAST_CODE);
            run_random(RANDOM_ITEMS);
        end

        settle();
        $display("covered %0d font loads and %0d renders, %0d columns checked",
                 sb.loads, sb.renders, sb.columns);
        $display("settings: reset, dense and sparse at widths 0 and 31, sparse 7, one random");
        if (sb.mismatches == 0) begin
            $display("font_glyph_column_streamer_top_tb: PASS");
        end else begin
            $display("font_glyph_column_streamer_top_tb: FAIL");
        end
        $finish;
    end

    // Watchdog: several times the slowest correct run.
    initial begin
        #(5_000_000);
        $display("[%0t] timeout, %0d columns still owed", $time, sb.pending());
        $display("font_glyph_column_streamer_top_tb: FAIL");
        $finish;
    end

endmodule

### font_glyph_column_streamer_top.f
rtl/core/fgcs_pkg.sv
rtl/core/fgcs_ram.sv
rtl/core/fgcs_ctrl.sv
rtl/core/fgcs_dpath.sv
rtl/core/font_glyph_column_streamer_top.sv
tb/sv/font_glyph_column_streamer_top_tb.sv
